FILE: rtl/sec_pkg.sv
// Shared types, constants and the escape function of the string escape encoder.
// Depends on nothing; sec_front, sec_queue, sec_back and the top import it.
`timescale 1ns / 1ps
`default_nettype none

package sec_pkg;

  localparam int SEC_MAX_CAPACITY = 1024;
  localparam int SEC_CAP_W        = 11;
  localparam int SEC_QDEPTH       = 4;

  localparam logic [SEC_CAP_W-1:0] SEC_CAP_RESET = 11'd900;

  // characters with a special meaning
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_DEL      = 8'h7f;

  localparam logic [7:0] SEC_HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // One escape sequence: up to four bytes, last_idx is length - 1
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] seq;
  } sec_entry_t;

  typedef struct packed {
    logic       valid;
    sec_entry_t entry;
  } sec_push_t;

  function automatic sec_entry_t sec_escape(input logic [7:0] b);
    sec_entry_t e;
    logic [7:0] second;
    second = CH_NUL;
    unique case (b)
      CH_BSL:   second = CH_BSL;
      CH_QUOTE: second = CH_QUOTE;
      CH_LF:    second = CH_N;
      CH_CR:    second = CH_R;
      CH_TAB:   second = CH_T;
      default:  second = CH_NUL;
    endcase
    e.seq      = '0;
    e.last_idx = 2'd0;
    if (second != CH_NUL) begin
      e.seq[0]   = CH_BSL;
      e.seq[1]   = second;
      e.last_idx = 2'd1;
    end else if (b >= CH_PRINT_LO && b < CH_DEL) begin
      e.seq[0]   = b;
    end else begin
      e.seq[0]   = CH_BSL;
      e.seq[1]   = CH_X;
      e.seq[2]   = SEC_HEX_DIGITS[b[7:4]];
      e.seq[3]   = SEC_HEX_DIGITS[b[3:0]];
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sec_if.sv
// Valid/ready channel interfaces of the string escape encoder: input byte,
// output byte and capacity write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface sec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface sec_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] capacity;
  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

FILE: rtl/sec_front.sv
// Front end: accepts source bytes, classifies them, applies the fit rule and
// queues escape sequences. Holds the capacity register. Uses sec_pkg, sec_if.
`timescale 1ns / 1ps
`default_nettype none

module sec_front
  import sec_pkg::*;
#(
  parameter int MAX_CAPACITY = SEC_MAX_CAPACITY
) (
  input  wire            clk,
  input  wire            rst_n,
  sec_in_if.sink         in_ch,
  sec_cfg_if.sink        cfg_ch,
  input  wire            q_full,
  output sec_push_t      push
);

  localparam int UW = $clog2(MAX_CAPACITY);
  localparam int EW = (SEC_CAP_W > UW + 1) ? SEC_CAP_W : UW + 1;
  localparam logic [EW-1:0] MAX_C = EW'(MAX_CAPACITY);

  logic [SEC_CAP_W-1:0] cap_r;
  logic [UW-1:0]        bytes_used_r, bytes_used_nxt;
  logic                 stopped_r, stopped_nxt;

  logic [EW-1:0] eff_cap;
  logic [EW:0]   sum;
  logic          fits;
  logic          accept;
  logic          is_zero;
  sec_entry_t    esc;
  sec_entry_t    term;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;

  assign accept  = in_ch.valid && in_ch.ready;
  assign is_zero = (in_ch.in_byte == CH_NUL);
  assign esc     = sec_escape(in_ch.in_byte);

  always_comb begin
    term          = '0;
    term.seq[0]   = CH_NUL;
    term.last_idx = 2'd0;
  end

  // zero reads as one, anything above the ceiling saturates
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap_r) > MAX_C) begin
      eff_cap = MAX_C;
    end else begin
      eff_cap = EW'(cap_r);
    end
  end

  assign sum  = (EW+1)'(bytes_used_r) + (EW+1)'({1'b0, esc.last_idx}) + (EW+1)'(1);
  assign fits = sum < {1'b0, eff_cap};

  assign push.valid = accept && (is_zero || (!stopped_r && fits));
  assign push.entry = is_zero ? term : esc;

  always_comb begin
    bytes_used_nxt = bytes_used_r;
    stopped_nxt    = stopped_r;
    if (accept) begin
      if (is_zero) begin
        bytes_used_nxt = '0;
        stopped_nxt    = 1'b0;
      end else if (!stopped_r) begin
        if (fits) begin
          bytes_used_nxt = UW'(sum);
        end else begin
          stopped_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= SEC_CAP_RESET;
      bytes_used_r <= '0;
      stopped_r    <= 1'b0;
    end else begin
      bytes_used_r <= bytes_used_nxt;
      stopped_r    <= stopped_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_r <= cfg_ch.capacity;
      end
    end
  end

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_zero |=> bytes_used_r == '0 && !stopped_r)
    else $error("terminator did not clear the string state");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_full)
    else $error("word pushed into a full queue");

  a_stopped_drops: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_zero && stopped_r |-> !push.valid && stopped_nxt)
    else $error("stopped string emitted a word");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(bytes_used_r) < MAX_C)
    else $error("byte count beyond buffer ceiling");

endmodule

`default_nettype wire

FILE: rtl/sec_queue.sv
// Short queue of escape sequences between front and back end.
// Uses sec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sec_queue
  import sec_pkg::*;
#(
  parameter int DEPTH = SEC_QDEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  input  sec_push_t  push,
  input  wire        pop,
  output logic       full,
  output logic       empty,
  output sec_entry_t head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  sec_entry_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sec_back.sv
// Back end: walks the head sequence one byte a cycle, when the output is not
// stalled, into the output register. Uses sec_pkg, sec_if.
`timescale 1ns / 1ps
`default_nettype none

module sec_back
  import sec_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  sec_entry_t head,
  input  wire        q_empty,
  output logic       pop,
  sec_out_if.source  out_ch
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       load;
  logic       at_last;

  assign load    = !q_empty && (!out_valid_r || out_ch.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = out_last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head.seq[idx_r];
      out_last_r <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= at_last ? 2'd0 : idx_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/string_escape_encoder.sv
// String escape encoder: takes one source byte per word and gives its C-style
// escaped form one byte per word, run_last marking the final byte of each sequence.
// The back end emits one byte per cycle while out_ch is ready, so an input yields 1,
// 2 or 4 output bytes (plain, two-byte escape, hex escape); a zero byte gives the
// single terminator byte and a dropped byte gives no output at all.
// Hex escapes set the sustained worst case, limited by the single output
// register. A queue of QUEUE_DEPTH sequences lets input run ahead of output.
// Capacity writes are taken in any cycle and act on the next input.
// Depends on sec_pkg, sec_if, sec_front, sec_queue, sec_back.
`timescale 1ns / 1ps
`default_nettype none

module string_escape_encoder
  import sec_pkg::*;
#(
  parameter int MAX_CAPACITY = SEC_MAX_CAPACITY,
  parameter int QUEUE_DEPTH  = SEC_QDEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  sec_in_if.sink     in_ch,
  sec_out_if.source  out_ch,
  sec_cfg_if.sink    cfg_ch
);

  sec_push_t  push;
  sec_entry_t head;
  logic       q_full;
  logic       q_empty;
  logic       pop;

  sec_front #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .push   (push)
  );

  sec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  sec_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
